// ===== hw/rtl/tlbpt_pkg.sv =====
// tlbpt_pkg: shared constants, types and command/status structs
// for the tlb page translation unit; no dependencies
`timescale 1ns / 1ps
package tlbpt_pkg;
   localparam int TLB_ENTRIES = 16;
   localparam int FRAME_COUNT = 128;
   localparam int AGE_LIMIT   = 1024;
   localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
   localparam int FRAME_IDX_W = $clog2(FRAME_COUNT);
   localparam int AGE_W       = $clog2(AGE_LIMIT + 1);
   localparam int PAGE_W      = 8;
   localparam int OFFSET_W    = 8;
   localparam int VA_W        = 16;
   localparam int PA_W        = 15;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_POLICY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TLB_POLICY   = 1'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TLB_SCAN,
      ST_FRAME_SCAN,
      ST_FRAME_PICK,
      ST_TLB_INVAL,
      ST_TLB_PICK,
      ST_FRAME_AGE,
      ST_TLB_AGE,
      ST_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_TLB_SCAN,
      OP_FRAME_SCAN,
      OP_FRAME_PICK,
      OP_TLB_INVAL,
      OP_TLB_PICK,
      OP_AGE
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   first;   // first step of a sweep
      logic [FRAME_IDX_W-1:0] index;   // sweep position
      logic                   commit;  // finish step (write result of sweep)
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic found;
   } status_type;
endpackage

// ===== hw/rtl/tlbpt_ctrl.sv =====
// tlbpt_ctrl: controller state machine that sequences the sweeps
// depends on tlbpt_pkg
`timescale 1ns / 1ps
module tlbpt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_fire,
   input  logic                 frame_policy,
   input  logic                 tlb_policy,
   input  tlbpt_pkg::status_type status,
   output tlbpt_pkg::cmd_type   cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import tlbpt_pkg::*;

   state_type state_ff, state_in;
   logic [FRAME_IDX_W:0] count_ff, count_in;

   // state and sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff + 1'b1;
      cmd.op    = OP_NONE;
      cmd.first = (count_ff == '0);
      cmd.index = count_ff[FRAME_IDX_W-1:0];
      cmd.commit = 1'b0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            count_in = '0;
            if (req_fire) begin
               cmd.op = OP_LOAD;
               state_in = ST_TLB_SCAN;
            end
         end
         ST_TLB_SCAN: begin
            cmd.op = OP_TLB_SCAN;
            if (count_ff == TLB_ENTRIES) begin
               cmd.op = OP_NONE;
               count_in = '0;
               if (status.hit) state_in = ST_FRAME_AGE;
               else state_in = ST_FRAME_SCAN;
            end
         end
         // one extra step compares the last frame read, one more to decide
         ST_FRAME_SCAN: begin
            cmd.op = OP_FRAME_SCAN;
            if (count_ff == FRAME_COUNT + 1) begin
               cmd.op = OP_NONE;
               count_in = '0;
               if (status.found) state_in = ST_TLB_PICK;
               else state_in = ST_FRAME_PICK;
            end
         end
         ST_FRAME_PICK: begin
            cmd.op = OP_FRAME_PICK;
            if (!frame_policy || count_ff == FRAME_COUNT) begin
               cmd.commit = 1'b1;
               count_in = '0;
               state_in = ST_TLB_INVAL;
            end
         end
         ST_TLB_INVAL: begin
            cmd.op = OP_TLB_INVAL;
            if (count_ff == TLB_ENTRIES - 1) begin
               count_in = '0;
               state_in = ST_TLB_PICK;
            end
         end
         ST_TLB_PICK: begin
            cmd.op = OP_TLB_PICK;
            if (!tlb_policy || count_ff == TLB_ENTRIES) begin
               cmd.commit = 1'b1;
               count_in = '0;
               state_in = ST_FRAME_AGE;
            end
         end
         // frame ages are written one step behind the registered read
         ST_FRAME_AGE: begin
            cmd.op = frame_policy ? OP_AGE : OP_NONE;
            if (!frame_policy || count_ff == FRAME_COUNT) begin
               count_in = '0;
               state_in = ST_TLB_AGE;
            end
         end
         ST_TLB_AGE: begin
            cmd.op = tlb_policy ? OP_AGE : OP_NONE;
            cmd.commit = 1'b1;
            if (!tlb_policy || count_ff == TLB_ENTRIES - 1) begin
               count_in = '0;
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            count_in = '0;
            rsp_valid = 1'b1;
            if (rsp_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== hw/rtl/tlbpt_datapath.sv =====
// tlbpt_datapath: tlb and inverted page table storage, sweep compare and
// victim logic; depends on tlbpt_pkg
`timescale 1ns / 1ps
module tlbpt_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  tlbpt_pkg::cmd_type      cmd,
   input  logic [tlbpt_pkg::VA_W-1:0] req_va,
   input  logic                    frame_policy,
   input  logic                    tlb_policy,
   output tlbpt_pkg::status_type   status,
   output logic [tlbpt_pkg::PA_W-1:0] rsp_pa,
   output logic                    rsp_hit,
   output logic                    rsp_fault
);
   import tlbpt_pkg::*;

   // tlb held in flip-flops, one row per entry
   logic [PAGE_W-1:0]      tag_ff   [TLB_ENTRIES];
   logic [FRAME_IDX_W-1:0] tframe_ff[TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tvalid_ff;
   logic [AGE_W-1:0]       tage_ff  [TLB_ENTRIES];
   // frame table memory: owner and age; valid bits in flops
   logic [PAGE_W-1:0]      owner_mem[FRAME_COUNT];
   logic [AGE_W-1:0]       fage_mem [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] fvalid_ff;

   logic [PAGE_W-1:0]      page_ff;
   logic [OFFSET_W-1:0]    offset_ff;
   logic [FRAME_IDX_W-1:0] frame_ff, ffifo_ff, best_f_ff;
   logic [TLB_IDX_W-1:0]   tfifo_ff, best_t_ff;
   logic [AGE_W-1:0]       best_age_ff;
   logic                   hit_ff, found_ff, fault_ff;
   logic [PAGE_W-1:0]      owner_rd_ff;
   logic [AGE_W-1:0]       fage_rd_ff;
   logic [FRAME_IDX_W-1:0] rd_idx_ff;
   logic                   rd_ok_ff;

   logic [TLB_IDX_W-1:0]   ti;
   logic [FRAME_IDX_W-1:0] fprev;
   logic [AGE_W-1:0]       fage_eff;
   assign ti    = cmd.index[TLB_IDX_W-1:0];
   assign fprev = cmd.index - 1'b1;

   // an unclaimed frame always reads as the age limit
   assign fage_eff = fvalid_ff[rd_idx_ff] ? fage_rd_ff : AGE_W'(AGE_LIMIT);

   // registered memory read, compared in the next cycle
   always_ff @(posedge clock) begin
      owner_rd_ff <= owner_mem[cmd.index];
      fage_rd_ff  <= fage_mem[cmd.index];
      rd_idx_ff   <= cmd.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= '0;
         fvalid_ff <= '0;
         ffifo_ff  <= '0;
         tfifo_ff  <= '0;
         rd_ok_ff  <= 1'b0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            tage_ff[i] <= AGE_W'(AGE_LIMIT);
            tag_ff[i] <= '0;
            tframe_ff[i] <= '0;
         end
      end else begin
         rd_ok_ff <= (cmd.op == OP_FRAME_SCAN || cmd.op == OP_FRAME_PICK ||
                      cmd.op == OP_AGE);
         case (cmd.op)
            // latch the request
            OP_LOAD: begin
               page_ff   <= req_va[VA_W-1:OFFSET_W];
               offset_ff <= req_va[OFFSET_W-1:0];
               hit_ff <= 1'b0; found_ff <= 1'b0; fault_ff <= 1'b0;
            end
            // first matching valid tlb entry
            OP_TLB_SCAN:
               if (!hit_ff && tvalid_ff[ti] && tag_ff[ti] == page_ff) begin
                  hit_ff <= 1'b1;
                  frame_ff <= tframe_ff[ti];
               end
            // first valid frame owned by the page (uses read of index-1)
            OP_FRAME_SCAN:
               if (!cmd.first && !found_ff && fvalid_ff[fprev] &&
                   owner_rd_ff == page_ff) begin
                  found_ff <= 1'b1;
                  frame_ff <= fprev;
               end
            // victim frame: fifo pointer or first oldest
            OP_FRAME_PICK: begin
               if (cmd.first) begin
                  best_age_ff <= '0;
                  best_f_ff <= '0;
               end else if (frame_policy && rd_ok_ff &&
                            (fprev == '0 || fage_eff > best_age_ff)) begin
                  best_age_ff <= fage_eff;
                  best_f_ff <= fprev;
               end
               if (cmd.commit) begin
                  logic [FRAME_IDX_W-1:0] v;
                  v = ffifo_ff;
                  if (frame_policy)
                     v = (fage_eff > best_age_ff) ? fprev : best_f_ff;
                  else
                     ffifo_ff <= ffifo_ff + 1'b1;
                  frame_ff <= v;
                  fault_ff <= 1'b1;
                  owner_mem[v] <= page_ff;
                  fvalid_ff[v] <= 1'b1;
                  // a frame claimed for the first time starts at the limit
                  if (!fvalid_ff[v]) fage_mem[v] <= AGE_W'(AGE_LIMIT);
               end
            end
            // drop tlb entries naming the reused frame
            OP_TLB_INVAL:
               if (tvalid_ff[ti] && tframe_ff[ti] == frame_ff) begin
                  tvalid_ff[ti] <= 1'b0;
                  tage_ff[ti] <= AGE_W'(AGE_LIMIT);
               end
            // tlb refill slot: fifo pointer or first oldest
            OP_TLB_PICK: begin
               if (cmd.first) begin
                  best_age_ff <= tage_ff[0];
                  best_t_ff <= '0;
               end else if (tlb_policy && cmd.index < FRAME_IDX_W'(TLB_ENTRIES) &&
                            tage_ff[ti] > best_age_ff) begin
                  best_age_ff <= tage_ff[ti];
                  best_t_ff <= ti;
               end
               if (cmd.commit) begin
                  logic [TLB_IDX_W-1:0] s;
                  s = tlb_policy ? best_t_ff : tfifo_ff;
                  if (!tlb_policy) tfifo_ff <= tfifo_ff + 1'b1;
                  tag_ff[s] <= page_ff;
                  tframe_ff[s] <= frame_ff;
                  tvalid_ff[s] <= 1'b1;
               end
            end
            // aging: frames from the registered read of index-1, then tlb rows
            OP_AGE: begin
               if (!cmd.commit) begin
                  if (!cmd.first) begin
                     if (fprev == frame_ff) fage_mem[fprev] <= '0;
                     else if (fage_eff < AGE_W'(AGE_LIMIT))
                        fage_mem[fprev] <= fage_eff + 1'b1;
                  end
               end else if (tvalid_ff[ti]) begin
                  if (tframe_ff[ti] == frame_ff) tage_ff[ti] <= '0;
                  else if (tage_ff[ti] < AGE_W'(AGE_LIMIT))
                     tage_ff[ti] <= tage_ff[ti] + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign status.hit   = hit_ff;
   assign status.found = found_ff;
   assign rsp_pa    = PA_W'({frame_ff, offset_ff});
   assign rsp_hit   = hit_ff;
   assign rsp_fault = fault_ff;
endmodule

// ===== hw/rtl/tlb_page_translation_unit.sv =====
// tlb_page_translation_unit: top level joining controller and datapath
// depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_datapath
`timescale 1ns / 1ps
// Usage
//   req channel carries one 16-bit virtual address per transfer
//   (page in bits 15:8, offset in bits 7:0); rsp carries the 15-bit
//   physical address in tdata and {page_fault, tlb_hit} in tuser.
//   One access at a time: req_tready is high only while idle.
//   From request transfer to rsp_tvalid, a tlb hit runs the tlb scan and
//   the aging sweeps; a miss adds a frame table scan, a victim pick
//   (fifo pointer, or a full sweep under lru), an invalidate pass over
//   the tlb and a tlb slot pick (fifo pointer, or a sweep under lru).
//   The aging sweeps run over the frames (frame lru) and the tlb rows
//   (tlb lru) and are skipped under fifo policies.
//   The time to the result is set by the one-entry-a-cycle sweeps over the
//   frame table memory port and the tlb rows.
//   After the result is taken the unit returns to idle before the next
//   request can be taken.
//   The result waits in its register while rsp_tready is low; no new
//   request is accepted until it is taken.
//   Reset (synchronous, active high) clears valid bits, pointers, ages
//   of the tlb and policies at once; unclaimed frames read as the age
//   limit, so there is no clearing pass.
//   csr writes (index 0 frame policy, 1 tlb policy) belong in idle time.
module tlb_page_translation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // virtual_address[15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // physical_address[14:0], zero pad
   output logic [1:0]  rsp_tuser,   // {page_fault, tlb_hit}
   input  logic        csr_we,
   input  logic [tlbpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        csr_wdata
);
   import tlbpt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic busy, frame_policy_ff, tlb_policy_ff;
   logic [PA_W-1:0] pa;
   logic hit, fault;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_policy_ff <= 1'b0;
         tlb_policy_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_POLICY: frame_policy_ff <= csr_wdata;
            CSR_TLB_POLICY:   tlb_policy_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !busy;

   tlbpt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_fire(req_tvalid && req_tready),
      .rsp_fire(rsp_tvalid && rsp_tready),
      .frame_policy(frame_policy_ff), .tlb_policy(tlb_policy_ff),
      .status(status), .cmd(cmd), .busy(busy), .rsp_valid(rsp_tvalid)
   );

   tlbpt_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_va(req_tdata),
      .frame_policy(frame_policy_ff), .tlb_policy(tlb_policy_ff),
      .status(status), .rsp_pa(pa), .rsp_hit(hit), .rsp_fault(fault)
   );

   assign rsp_tdata = {1'b0, pa};
   assign rsp_tuser = {fault, hit};
endmodule

// ===== hw/rtl/tlbpt_checker.sv =====
// tlbpt_checker: port-level assertions for the translation unit
// depends on tlb_page_translation_unit ports
`timescale 1ns / 1ps
module tlbpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   // one access in flight: no request taken while a result is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready)) else $error("ready during response");
   // a hit never reports a fault
   a_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1])) else $error("hit and fault");
   // accepted request never gives a result the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid) else $error("early response");
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped");
endmodule

bind tlb_page_translation_unit tlbpt_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
   .req_tready(req_tready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);
